// ===== rtl/core/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  typedef enum logic {
    FUNC_DATA    = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    PH_LEAD   = 7'b0000001,
    PH_DIGITS = 7'b0000010,
    PH_DATA   = 7'b0000100,
    PH_END_CR = 7'b0001000,
    PH_END_LF = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERR    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       chunk_last;
    logic [1:0] status;
  } out_beat_t;

  // Hex digit decode: bit 4 flags a hex character, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder_top.sv =====
`default_nettype none
// Chunked HTTP body decoder.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per raw byte of
// the chunked body. A beat with func set restarts decoding of a new body; its
// byte is ignored.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one beat for
// every input beat, in order. payload_valid marks a chunk payload byte and
// chunk_last marks the final byte of its chunk; status reports in progress,
// body complete or framing error as it stands after that byte. Complete and
// error hold until a restart beat.
// Each result beat is registered in the result or the skid register.
// Throughput: one byte per cycle while in_stall_o is low; the decode of a byte
// is a single pass through the size-line and chunk logic, so the next byte can
// follow at once. Stall: a two-entry output buffer (result register plus skid
// register) lets one more byte be taken while a result waits; in_stall_o rises
// only while the skid register is full, and no beat is lost or repeated.
// Reset: rst_ni clears the decoder to the start of a size line and empties
// both output entries; no clearing pass is needed.
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  localparam logic [SIZE_BITS-1:0] SIZE_ONES = {SIZE_BITS{1'b1}};

  // Decoder state
  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_accum_q, size_accum_d;
  logic                 saw_line_q, saw_line_d;
  logic                 digits_ended_q, digits_ended_d;
  logic                 cr_pending_q, cr_pending_d;
  logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;

  // Output buffer
  logic      out_valid_q, skid_valid_q;
  out_beat_t out_q, skid_q;
  out_beat_t res;

  logic       in_fire, out_fire;
  logic       is_restart;
  logic [7:0] b;
  logic [4:0] hx;
  logic       is_blank;
  logic [SIZE_BITS-1:0] accum_next;

  assign in_fire  = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  assign is_restart = (in_data_i.func == FUNC_RESTART);
  assign b          = in_data_i.data_byte;
  assign hx         = hex_decode(b);
  assign is_blank   = b inside {CHAR_SP, CHAR_TAB};

  // Shift in one hex digit; saturate once the top nibble is occupied.
  assign accum_next = (|size_accum_q[SIZE_BITS-1 -: 4]) ? SIZE_ONES
                    : {size_accum_q[SIZE_BITS-5:0], hx[3:0]};

  always_comb begin
    phase_d        = phase_q;
    size_accum_d   = size_accum_q;
    saw_line_d     = saw_line_q;
    digits_ended_d = digits_ended_q;
    cr_pending_d   = cr_pending_q;
    bytes_left_d   = bytes_left_q;
    res            = '0;

    if (is_restart) begin
      // Restart: back to the start of a size line
      phase_d        = PH_LEAD;
      size_accum_d   = '0;
      saw_line_d     = 1'b0;
      digits_ended_d = 1'b0;
      cr_pending_d   = 1'b0;
      bytes_left_d   = '0;
    end else begin
      case (phase_q)
        PH_LEAD, PH_DIGITS: begin
          if (cr_pending_q && b == CHAR_LF) begin
            // End of size line
            if (!saw_line_q) begin
              phase_d = PH_ERR;
            end else if (size_accum_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              bytes_left_d = size_accum_q;
              phase_d      = PH_DATA;
            end
            size_accum_d   = '0;
            saw_line_d     = 1'b0;
            digits_ended_d = 1'b0;
            cr_pending_d   = 1'b0;
          end else if (cr_pending_q) begin
            // Lone CR counts as a non-hex line byte and ends the digits
            saw_line_d     = 1'b1;
            digits_ended_d = 1'b1;
            cr_pending_d   = (b == CHAR_CR);
          end else if (b == CHAR_CR) begin
            cr_pending_d = 1'b1;
          end else begin
            saw_line_d = 1'b1;
            if (!digits_ended_q && !(phase_q == PH_LEAD && is_blank)) begin
              if (!hx[4]) begin
                digits_ended_d = 1'b1;
              end else begin
                phase_d      = PH_DIGITS;
                size_accum_d = accum_next;
              end
            end
          end
        end
        PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          bytes_left_d      = bytes_left_q - SIZE_BITS'(1);
          if (bytes_left_d == '0) begin
            res.chunk_last = 1'b1;
            phase_d        = PH_END_CR;
          end
        end
        PH_END_CR: begin
          phase_d = (b == CHAR_CR) ? PH_END_LF : PH_ERR;
        end
        PH_END_LF: begin
          if (b == CHAR_LF) begin
            phase_d        = PH_LEAD;
            size_accum_d   = '0;
            saw_line_d     = 1'b0;
            digits_ended_d = 1'b0;
            cr_pending_d   = 1'b0;
          end else begin
            phase_d = PH_ERR;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_ERR;
        end
      endcase
    end

    if (phase_d == PH_DONE) begin
      res.status = ST_DONE;
    end else if (phase_d == PH_ERR) begin
      res.status = ST_ERROR;
    end else begin
      res.status = ST_BUSY;
    end
  end

  // Advance decoder state on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_LEAD;
      size_accum_q   <= '0;
      saw_line_q     <= 1'b0;
      digits_ended_q <= 1'b0;
      cr_pending_q   <= 1'b0;
      bytes_left_q   <= '0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      size_accum_q   <= size_accum_d;
      saw_line_q     <= saw_line_d;
      digits_ended_q <= digits_ended_d;
      cr_pending_q   <= cr_pending_d;
      bytes_left_q   <= bytes_left_d;
    end
  end

  // Output buffer control: drain skid first, else load the fresh result;
  // park the result in the skid register while the output beat is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A full skid register implies a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // Chunk end marks only payload beats
  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.chunk_last |-> out_q.payload_valid)
    else $error("chunk_last on non-payload beat");

  // A restart beat leaves the decoder at the start of a size line
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_restart |=> phase_q == PH_LEAD && bytes_left_q == '0)
    else $error("restart did not clear decoder");

  // Payload is emitted only while a chunk still has bytes due
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_DATA && !is_restart |-> bytes_left_q != '0)
    else $error("payload phase with no bytes left");

  // Complete holds until restart
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_DONE && !is_restart |=> phase_q == PH_DONE)
    else $error("complete state left without restart");

endmodule

`default_nettype wire
